@@ hdl/pzte_pkg.sv @@
// Shared constants and types for the pole-zero trapezoid energy filter.
`default_nettype none

package pzte_pkg;

  // Default build sizes
  localparam int DefMaxWindow  = 256;
  localparam int DefMaxGap     = 64;
  localparam int DefSampleBits = 16;

  // Fixed field widths
  localparam int SampleWidth   = 16;
  localparam int OutWidth      = 42;
  localparam int WinLenWidth   = 9;
  localparam int GapLenWidth   = 7;
  localparam int WeightWidth   = 32;
  localparam int BaselineWidth = 16;

  // APB port
  localparam int ApbAddrWidth  = 5;
  localparam int ApbDataWidth  = 32;
  localparam int RegIdxWidth   = 3;

  localparam logic [RegIdxWidth-1:0] RegWindowLength  = 3'd0;
  localparam logic [RegIdxWidth-1:0] RegGapLength     = 3'd1;
  localparam logic [RegIdxWidth-1:0] RegLeadWeight    = 3'd2;
  localparam logic [RegIdxWidth-1:0] RegTrailWeight   = 3'd3;
  localparam logic [RegIdxWidth-1:0] RegBaselineLevel = 3'd4;

  localparam logic [WinLenWidth-1:0]   RstWindowLength  = 9'd200;
  localparam logic [GapLenWidth-1:0]   RstGapLength     = 7'd30;
  localparam logic [WeightWidth-1:0]   RstLeadWeight    = 32'hFFFF_0000;
  localparam logic [WeightWidth-1:0]   RstTrailWeight   = 32'h0001_0000;
  localparam logic [BaselineWidth-1:0] RstBaselineLevel = 16'd0;

  typedef struct packed {
    logic [WinLenWidth-1:0]   window_length;
    logic [GapLenWidth-1:0]   gap_length;
    logic [WeightWidth-1:0]   lead_weight;
    logic [WeightWidth-1:0]   trail_weight;
    logic [BaselineWidth-1:0] baseline_level;
  } pzte_cfg_t;

endpackage

`default_nettype wire

@@ hdl/pzte_ram.sv @@
// Generic single-write, single-read RAM with registered read data (read-first).
`default_nettype none

module pzte_ram #(
  parameter int Width = 16,
  parameter int Depth = 576
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/pzte_regs.sv @@
// APB configuration registers of the energy filter.
`default_nettype none

module pzte_regs
  import pzte_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ApbAddrWidth-1:0] paddr,
  input  wire logic [ApbDataWidth-1:0] pwdata,
  output logic      [ApbDataWidth-1:0] prdata,
  output logic                         pready,
  output pzte_cfg_t                    cfg_o,
  output logic                         restart_o
);

  pzte_cfg_t              cfg_q, cfg_d;
  logic                   wr_en;
  logic [RegIdxWidth-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[ApbAddrWidth-1:2];
  assign wr_en  = psel && penable && pwrite;

  // changing the window or gap length invalidates the running sums
  assign restart_o = wr_en && ((idx == RegWindowLength) || (idx == RegGapLength));

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegWindowLength:  cfg_d.window_length  = pwdata[WinLenWidth-1:0];
        RegGapLength:     cfg_d.gap_length     = pwdata[GapLenWidth-1:0];
        RegLeadWeight:    cfg_d.lead_weight    = pwdata[WeightWidth-1:0];
        RegTrailWeight:   cfg_d.trail_weight   = pwdata[WeightWidth-1:0];
        RegBaselineLevel: cfg_d.baseline_level = pwdata[BaselineWidth-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length  <= RstWindowLength;
      cfg_q.gap_length     <= RstGapLength;
      cfg_q.lead_weight    <= RstLeadWeight;
      cfg_q.trail_weight   <= RstTrailWeight;
      cfg_q.baseline_level <= RstBaselineLevel;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      RegWindowLength:  prdata = ApbDataWidth'(cfg_q.window_length);
      RegGapLength:     prdata = ApbDataWidth'(cfg_q.gap_length);
      RegLeadWeight:    prdata = cfg_q.lead_weight;
      RegTrailWeight:   prdata = cfg_q.trail_weight;
      RegBaselineLevel: prdata = ApbDataWidth'(cfg_q.baseline_level);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hdl/pole_zero_trapezoid_energy_filter.sv @@
// Top level: trapezoidal energy filter with pole-zero weighted window sums.
//
//   port group      dir  handshake               payload
//   sample in       in   in_valid_i/in_stall_o   sample_i, trace_start_i
//   filter out      out  out_valid_o/out_stall_i energy_o, value_valid_o
//   config (APB)    in   psel/penable/pready     paddr, pwdata, prdata
//
// One sample per clock sustained while the output is not stalled. Five register stages
// (history RAM read, running-sum update, baseline subtract, weight multiply, final add);
// the first loads at the accepting edge and each result moves through the rest in order.
// The three history RAMs are read at ages L, L+G and 2L+G of the newest sample.
// Reset needs no RAM clearing pass: entries older than the trace are masked by the
// sample count. A stall on the output holds every full stage; empty stages still fill.
`default_nettype none

module pole_zero_trapezoid_energy_filter
  import pzte_pkg::*;
#(
  parameter int MaxWindow  = DefMaxWindow,
  parameter int MaxGap     = DefMaxGap,
  parameter int SampleBits = DefSampleBits
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [SampleWidth-1:0]     sample_i,
  input  wire logic                       trace_start_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [OutWidth-1:0]      energy_o,
  output logic                            value_valid_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ApbAddrWidth-1:0]    paddr,
  input  wire logic [ApbDataWidth-1:0]    pwdata,
  output logic      [ApbDataWidth-1:0]    prdata,
  output logic                            pready
);

  localparam int Hist   = 2 * MaxWindow + MaxGap;
  localparam int AddrW  = $clog2(Hist);
  localparam int SpanW  = $clog2(Hist + 1);
  localparam int LenW   = $clog2(MaxWindow + 1);
  localparam int GapW   = ($clog2(MaxGap + 1) > 0) ? $clog2(MaxGap + 1) : 1;
  localparam int SumW   = SampleBits + LenW;
  localparam int GSumW  = SampleBits + GapW;
  localparam int BlW    = BaselineWidth + LenW;
  localparam int BgW    = BaselineWidth + GapW;
  localparam int DW     = BlW + 1;
  localparam int DgW    = BgW + 1;
  localparam int PW     = WeightWidth + DW;
  localparam int NW     = ((PW > DgW + 16) ? PW : DgW + 16) + 2;

  // ---------------------------------------------------------------- config
  pzte_cfg_t cfg;
  logic      restart;

  pzte_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  logic [SpanW-1:0] len_c, gap_c, lg_c, span_c;

  always_comb begin
    if (cfg.window_length == '0) begin
      len_c = SpanW'(1);
    end else if (32'(cfg.window_length) > 32'(MaxWindow)) begin
      len_c = SpanW'(MaxWindow);
    end else begin
      len_c = SpanW'(cfg.window_length);
    end
    if (32'(cfg.gap_length) > 32'(MaxGap)) begin
      gap_c = SpanW'(MaxGap);
    end else begin
      gap_c = SpanW'(cfg.gap_length);
    end
  end

  assign lg_c   = len_c + gap_c;
  assign span_c = SpanW'({len_c, 1'b0}) + gap_c;

  // baseline times window lengths, refreshed every cycle
  logic [BlW-1:0] blen_q;
  logic [BgW-1:0] bgap_q;

  always_ff @(posedge clk_i) begin
    blen_q <= BlW'(cfg.baseline_level) * BlW'(len_c);
    bgap_q <= BgW'(cfg.baseline_level) * BgW'(gap_c);
  end

  // ---------------------------------------------------------------- flow control
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic adv1, adv2, adv3, adv4, adv_o, accept;

  assign adv_o  = !out_v_q || !out_stall_i;
  assign adv4   = !s4_v_q || adv_o;
  assign adv3   = !s3_v_q || adv4;
  assign adv2   = !s2_v_q || adv3;
  assign adv1   = !s1_v_q || adv2;
  assign in_stall_o = !adv1;
  assign accept = in_valid_i && adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv1)  s1_v_q  <= in_valid_i;
      if (adv2)  s2_v_q  <= s1_v_q;
      if (adv3)  s3_v_q  <= s2_v_q;
      if (adv4)  s4_v_q  <= s3_v_q;
      if (adv_o) out_v_q <= s4_v_q;
    end
  end

  // ---------------------------------------------------------------- stage 0
  logic [SpanW-1:0] seen_q, seen_d, s_c;
  logic [AddrW-1:0] wp_q, wp_d;
  logic [SampleBits-1:0] x_c;

  function automatic logic [AddrW-1:0] age_addr(input logic [AddrW-1:0] wp,
                                                input logic [SpanW-1:0] age);
    logic [SpanW:0] w;
    logic [SpanW:0] a;
    logic [SpanW:0] r;
    w = (SpanW + 1)'(wp);
    a = (SpanW + 1)'(age);
    if (w >= a) begin
      r = w - a;
    end else begin
      r = w + (SpanW + 1)'(Hist) - a;
    end
    return AddrW'(r);
  endfunction

  assign x_c    = sample_i[SampleBits-1:0];
  assign s_c    = trace_start_i ? '0 : seen_q;
  assign seen_d = (s_c < span_c) ? s_c + 1'b1 : s_c;
  assign wp_d   = (wp_q == AddrW'(Hist - 1)) ? '0 : wp_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      wp_q   <= '0;
    end else if (restart) begin
      seen_q <= '0;
    end else if (accept) begin
      seen_q <= seen_d;
      wp_q   <= wp_d;
    end
  end

  // history copies, one per read age; read-first covers age 2L+G == depth
  logic [SampleBits-1:0] rd_l, rd_lg, rd_sp;

  pzte_ram #(.Width(SampleBits), .Depth(Hist)) u_ram_l (
    .clk_i (clk_i), .we_i (accept), .waddr_i (wp_d), .wdata_i (x_c),
    .re_i (accept), .raddr_i (age_addr(wp_d, len_c)), .rdata_o (rd_l)
  );

  pzte_ram #(.Width(SampleBits), .Depth(Hist)) u_ram_lg (
    .clk_i (clk_i), .we_i (accept), .waddr_i (wp_d), .wdata_i (x_c),
    .re_i (accept), .raddr_i (age_addr(wp_d, lg_c)), .rdata_o (rd_lg)
  );

  pzte_ram #(.Width(SampleBits), .Depth(Hist)) u_ram_sp (
    .clk_i (clk_i), .we_i (accept), .waddr_i (wp_d), .wdata_i (x_c),
    .re_i (accept), .raddr_i (age_addr(wp_d, span_c)), .rdata_o (rd_sp)
  );

  // ---------------------------------------------------------------- stage 1
  logic [SampleBits-1:0] s1_x_q;
  logic s1_restart_q, s1_tout_q, s1_gin_q, s1_gout_q, s1_lin_q, s1_lout_q, s1_vv_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q       <= x_c;
      s1_restart_q <= trace_start_i;
      s1_tout_q    <= (len_c <= s_c);   // sample leaving trail was counted
      s1_gin_q     <= (len_c < seen_d);
      s1_gout_q    <= (lg_c <= s_c);
      s1_lin_q     <= (lg_c < seen_d);
      s1_lout_q    <= (s_c >= span_c);
      s1_vv_q      <= (seen_d >= span_c);
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [SumW-1:0]  trail_q, lead_q, trail_d, lead_d, base_t, base_l;
  logic [GSumW-1:0] gap_q, gap_d, base_g;
  logic             s2_vv_q;

  assign base_t = s1_restart_q ? '0 : trail_q;
  assign base_g = s1_restart_q ? '0 : gap_q;
  assign base_l = s1_restart_q ? '0 : lead_q;

  assign trail_d = base_t + SumW'(s1_x_q) - (s1_tout_q ? SumW'(rd_l) : '0);
  assign gap_d   = base_g + (s1_gin_q ? GSumW'(rd_l) : '0)
                          - (s1_gout_q ? GSumW'(rd_lg) : '0);
  assign lead_d  = base_l + (s1_lin_q ? SumW'(rd_lg) : '0)
                          - (s1_lout_q ? SumW'(rd_sp) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trail_q <= '0;
      gap_q   <= '0;
      lead_q  <= '0;
    end else if (restart) begin
      trail_q <= '0;
      gap_q   <= '0;
      lead_q  <= '0;
    end else if (s1_v_q && adv2) begin
      trail_q <= trail_d;
      gap_q   <= gap_d;
      lead_q  <= lead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) s2_vv_q <= s1_vv_q;
  end

  // ---------------------------------------------------------------- stage 3
  logic signed [DW-1:0]  dl_q, dt_q;
  logic signed [DgW-1:0] dg_q;
  logic                  s3_vv_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      dl_q    <= $signed(DW'(lead_q)) - $signed(DW'(blen_q));
      dt_q    <= $signed(DW'(trail_q)) - $signed(DW'(blen_q));
      dg_q    <= $signed(DgW'(gap_q)) - $signed(DgW'(bgap_q));
      s3_vv_q <= s2_vv_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic signed [PW-1:0]  p0_d, p1_d, p0_q, p1_q;
  logic signed [DgW-1:0] dg4_q;
  logic                  s4_vv_q;

  assign p0_d = $signed(cfg.lead_weight) * dl_q;
  assign p1_d = $signed(cfg.trail_weight) * dt_q;

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      p0_q    <= p0_d;
      p1_q    <= p1_d;
      dg4_q   <= dg_q;
      s4_vv_q <= s3_vv_q;
    end
  end

  // ---------------------------------------------------------------- output
  logic signed [NW-1:0]       num_c, shifted_c;
  logic signed [OutWidth-1:0] fv_q;
  logic                       vv_q;

  // gap weight is exactly 1.0 in Q16.16; arithmetic shift floors
  assign num_c     = NW'(p0_q) + NW'(p1_q) + (NW'(dg4_q) <<< 16);
  assign shifted_c = num_c >>> 16;

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      fv_q <= s4_vv_q ? OutWidth'(shifted_c) : '0;
      vv_q <= s4_vv_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign energy_o       = fv_q;
  assign value_valid_o  = vv_q;

endmodule

`default_nettype wire
